// ===== rtl/rau_pkg.sv =====
// Shared constants, operation codes and types for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
  localparam int NUM_WIDTH = 32;
  localparam int DEN_WIDTH = NUM_WIDTH - 1;
  localparam int WIDE      = 64;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_GT  = 4'd5;
  localparam logic [3:0] OP_GTE = 4'd6;
  localparam logic [3:0] OP_LT  = 4'd7;
  localparam logic [3:0] OP_LTE = 4'd8;
  localparam logic [3:0] OP_EQ  = 4'd9;

  // Divider request: unsigned 64-bit dividend over divisor.
  typedef struct packed {
    logic            start;
    logic [WIDE-1:0] dividend;
    logic [WIDE-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [WIDE-1:0] quot;
    logic [WIDE-1:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level: sequencer around one multiplier and the shared divider.
// Compares and errors go through S_M1-S_M3 and S_COMB; other operations
// use the shared 64-bit divider: Euclid steps and two final reductions,
// or one division for mod. One item at a time; in_stall is high while busy.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any pending result.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [3:0]          in_operation,
  input  wire  signed [31:0]  in_a_numer,
  input  wire  [30:0]         in_a_denom,
  input  wire  signed [31:0]  in_b_numer,
  input  wire  [30:0]         in_b_denom,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [63:0]  out_res_numer,
  output logic [62:0]         out_res_denom,
  output logic                out_compare_true,
  output logic                out_status
);
  localparam logic [3:0] S_IDLE = 4'd0, S_M1 = 4'd1, S_M2 = 4'd2, S_M3 = 4'd3,
                         S_COMB = 4'd4, S_GST = 4'd5, S_GWT = 4'd6, S_QN = 4'd7,
                         S_QNW = 4'd8, S_QD = 4'd9, S_QDW = 4'd10, S_MODW = 4'd11,
                         S_OUT = 4'd12;

  logic [3:0]  st_r, st_nxt;
  logic [3:0]  op_r;
  logic signed [NUM_WIDTH-1:0] an_r, bn_r;
  logic [DEN_WIDTH-1:0]        ad_r, bd_r;
  logic signed [WIDE-1:0] p0_r, p1_r, p2_r;   // lhs, rhs, extra product
  logic [WIDE-1:0] mn_r, md_r, gx_r, gy_r;
  logic            neg_r;
  logic signed [NUM_WIDTH:0]   mul_a, mul_b;
  logic signed [WIDE-1:0]      mul_p;
  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [WIDE-1:0] n_s, d_s;

  rau_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Single shared multiplier, operands picked by state.
  always_comb begin
    mul_a = {an_r[NUM_WIDTH-1], an_r};
    mul_b = {2'b00, bd_r};
    case (st_r)
      // Multiply needs the denominator product in place of lhs.
      S_M1: begin
        if (op_r == OP_MUL) begin
          mul_a = {2'b00, ad_r}; mul_b = {2'b00, bd_r};
        end
      end
      S_M2: begin mul_a = {bn_r[NUM_WIDTH-1], bn_r}; mul_b = {2'b00, ad_r}; end
      S_M3: begin
        if (op_r == OP_MUL) begin
          mul_a = {an_r[NUM_WIDTH-1], an_r}; mul_b = {bn_r[NUM_WIDTH-1], bn_r};
        end else begin
          mul_a = {2'b00, ad_r}; mul_b = {2'b00, bd_r};
        end
      end
      default: ;
    endcase
    mul_p = WIDE'(mul_a * mul_b);
  end

  always_comb begin
    n_s = p0_r + p1_r;
    d_s = p2_r;
    case (op_r)
      OP_SUB: n_s = p0_r - p1_r;
      OP_MUL: begin n_s = p2_r; d_s = p0_r; end
      OP_DIV: begin n_s = p0_r; d_s = p1_r; end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    dreq = '0;
    unique case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_M1;
      S_M1:   st_nxt = S_M2;
      S_M2:   st_nxt = S_M3;
      S_M3:   st_nxt = S_COMB;
      S_COMB: begin
        if (op_r == OP_MOD && bn_r != '0) begin
          dreq.start = 1'b1;
          dreq.dividend = an_r[NUM_WIDTH-1] ? WIDE'(-$signed(WIDE'(an_r))) : WIDE'(an_r);
          dreq.divisor  = bn_r[NUM_WIDTH-1] ? WIDE'(-$signed(WIDE'(bn_r))) : WIDE'(bn_r);
          st_nxt = S_MODW;
        end else if (op_r <= OP_DIV && !(op_r == OP_DIV && bn_r == '0)) begin
          st_nxt = S_GST;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_GST: begin
        if (gx_r == '0) st_nxt = (gy_r == '0) ? S_OUT : S_QN;
        else begin
          dreq.start = 1'b1; dreq.dividend = gy_r; dreq.divisor = gx_r;
          st_nxt = S_GWT;
        end
      end
      S_GWT: if (drsp.done) st_nxt = S_GST;
      S_QN: begin
        dreq.start = 1'b1; dreq.dividend = mn_r; dreq.divisor = gy_r;
        st_nxt = S_QNW;
      end
      S_QNW: if (drsp.done) st_nxt = S_QD;
      S_QD: begin
        dreq.start = 1'b1; dreq.dividend = md_r; dreq.divisor = gy_r;
        st_nxt = S_QDW;
      end
      S_QDW: if (drsp.done) st_nxt = S_OUT;
      S_MODW: if (drsp.done) st_nxt = S_OUT;
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
    case (st_r)
      S_IDLE: begin
        op_r <= in_operation;
        an_r <= in_a_numer[NUM_WIDTH-1:0]; bn_r <= in_b_numer[NUM_WIDTH-1:0];
        ad_r <= in_a_denom[DEN_WIDTH-1:0]; bd_r <= in_b_denom[DEN_WIDTH-1:0];
        out_res_numer <= '0; out_res_denom <= '0;
        out_compare_true <= 1'b0; out_status <= 1'b0;
      end
      S_M1: p0_r <= mul_p;
      S_M2: p1_r <= mul_p;
      S_M3: p2_r <= mul_p;
      S_COMB: begin
        neg_r <= n_s[WIDE-1] != d_s[WIDE-1];
        mn_r <= n_s[WIDE-1] ? WIDE'(-n_s) : n_s;
        md_r <= d_s[WIDE-1] ? WIDE'(-d_s) : d_s;
        gx_r <= n_s[WIDE-1] ? WIDE'(-n_s) : n_s;
        gy_r <= d_s[WIDE-1] ? WIDE'(-d_s) : d_s;
        case (op_r)
          OP_GT:  out_compare_true <= p0_r >  p1_r;
          OP_GTE: out_compare_true <= p0_r >= p1_r;
          OP_LT:  out_compare_true <= p0_r <  p1_r;
          OP_LTE: out_compare_true <= p0_r <= p1_r;
          OP_EQ:  out_compare_true <= p0_r == p1_r;
          OP_DIV, OP_MOD: out_status <= (bn_r == '0);
          default: ;
        endcase
      end
      S_GWT: if (drsp.done) begin gy_r <= gx_r; gx_r <= drsp.rem; end
      S_QNW: if (drsp.done) begin
        out_res_numer <= (neg_r && drsp.quot != '0) ? -$signed(drsp.quot)
                                                    : $signed(drsp.quot);
      end
      S_QDW: if (drsp.done) out_res_denom <= drsp.quot[WIDE-2:0];
      S_MODW: if (drsp.done) begin
        out_res_numer <= an_r[NUM_WIDTH-1] ? -$signed(drsp.rem) : $signed(drsp.rem);
        out_res_denom <= 63'd1;
      end
      default: ;
    endcase
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall)) else $error("ready while result pending");
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid) else $error("result repeated");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> st_r == S_M1) else $error("item not started");
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_res_denom == '0 && !out_status)
    else $error("compare with payload");
endmodule
`default_nettype wire

// ===== rtl/rau_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module rau_div import rau_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [WIDE-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [WIDE:0]   trial;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r, q_r[WIDE-1]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.dividend; r_nxt = '0; d_nxt = req.divisor;
      cnt_nxt = 7'(WIDE); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[WIDE]) begin
        r_nxt = trial[WIDE-1:0];
        q_nxt = {q_r[WIDE-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[WIDE-2:0], q_r[WIDE-1]};
        q_nxt = {q_r[WIDE-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;
endmodule
`default_nettype wire

// ===== tb/rational_arithmetic_unit_test.sv =====
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 100ps

module rational_arithmetic_unit_test;
  import rau_pkg::*;

  localparam longint CYCLE_LIMIT = 60_000_000;
  localparam int     RANDOM_ITEMS = 1630;

  typedef struct {
    logic signed [63:0] numer;
    logic [62:0]        denom;
    logic               cmp;
    logic               status;
  } rat_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_operation;
  logic signed [31:0] in_a_numer;
  logic [30:0]        in_a_denom;
  logic signed [31:0] in_b_numer;
  logic [30:0]        in_b_denom;
  logic               out_valid;
  logic               out_stall;
  logic signed [63:0] out_res_numer;
  logic [62:0]        out_res_denom;
  logic               out_compare_true;
  logic               out_status;

  int     hold_req;
  longint cycles;

  class rational_scoreboard;
    rat_result_t expected_q[$];
    int          errors;

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (x != 0) begin
        t = y % x;
        y = x;
        x = t;
      end
      return y;
    endfunction

    function automatic void reduce(longint n, longint d, ref rat_result_t r);
      logic            neg;
      longint unsigned mn;
      longint unsigned md;
      longint unsigned g;
      neg = (n < 0) != (d < 0);
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      g = euclid_gcd(mn, md);
      if (g != 0) begin
        mn = mn / g;
        md = md / g;
      end
      if (mn == 0) neg = 1'b0;
      r.numer = neg ? -mn : mn;
      r.denom = md[62:0];
    endfunction

    // Work out the result for one accepted item and queue it.
    function automatic void note(logic [3:0] op, logic signed [31:0] a_n, logic [30:0] a_d,
                                 logic signed [31:0] b_n, logic [30:0] b_d);
      rat_result_t r;
      longint an, ad, bn, bd, lhs, rhs;
      an = a_n;
      ad = longint'({33'b0, a_d});
      bn = b_n;
      bd = longint'({33'b0, b_d});
      lhs = an * bd;
      rhs = bn * ad;
      r = '{numer: 0, denom: 0, cmp: 0, status: 0};
      case (op)
        OP_ADD: reduce(lhs + rhs, ad * bd, r);
        OP_SUB: reduce(lhs - rhs, ad * bd, r);
        OP_MUL: reduce(an * bn, ad * bd, r);
        OP_DIV: begin
          if (bn == 0) r.status = 1'b1;
          else reduce(an * bd, ad * bn, r);
        end
        OP_MOD: begin
          if (bn == 0) r.status = 1'b1;
          else begin
            r.numer = an % bn;
            r.denom = 1;
          end
        end
        OP_GT:  r.cmp = lhs > rhs;
        OP_GTE: r.cmp = lhs >= rhs;
        OP_LT:  r.cmp = lhs < rhs;
        OP_LTE: r.cmp = lhs <= rhs;
        OP_EQ:  r.cmp = lhs == rhs;
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
    endtask

    task check(logic signed [63:0] n, logic [62:0] d, logic c, logic s);
      rat_result_t e;
      if (expected_q.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (n !== e.numer) report($sformatf("numer %0d, want %0d", n, e.numer));
      if (d !== e.denom) report($sformatf("denom %0d, want %0d", d, e.denom));
      if (c !== e.cmp) report($sformatf("compare_true %0b, want %0b", c, e.cmp));
      if (s !== e.status) report($sformatf("status %0b, want %0b", s, e.status));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  rational_scoreboard rat_sb;

  rational_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_a_numer(in_a_numer), .in_a_denom(in_a_denom),
    .in_b_numer(in_b_numer), .in_b_denom(in_b_denom),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_numer(out_res_numer), .out_res_denom(out_res_denom),
    .out_compare_true(out_compare_true), .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: check accepted items, stall at random or for a requested stretch.
  initial begin
    int calm;
    calm = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        rat_sb.check(out_res_numer, out_res_denom, out_compare_true, out_status);
      if (calm == 0 && $urandom_range(0, 199) == 0) calm = $urandom_range(200, 2000);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        hold_req--;
      end else if (calm > 0) begin
        out_stall <= 1'b0;
        calm--;
      end else begin
        out_stall <= (idle_len() != 0);
      end
    end
  end

  task send_item(logic [3:0] op, logic signed [31:0] a_n, logic [30:0] a_d,
                 logic signed [31:0] b_n, logic [30:0] b_d, int gap);
    in_valid <= 1'b1;
    in_operation <= op;
    in_a_numer <= a_n;
    in_a_denom <= a_d;
    in_b_numer <= b_n;
    in_b_denom <= b_d;
    do @(posedge clk); while (in_stall);
    rat_sb.note(op, a_n, a_d, b_n, b_d);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_numer(int mode);
    case (mode)
      0: return $urandom_range(0, 40) - 20;
      1: case ($urandom_range(0, 4))
           0: return 32'sh7fffffff;
           1: return 32'sh80000000;
           2: return -1;
           3: return 0;
           default: return 1;
         endcase
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_denom(int mode);
    case (mode)
      0: return $urandom_range(1, 24);
      1: return $urandom_range(0, 1) ? 31'h7fffffff : 31'd1;
      default: return $urandom_range(1, 32'h7fffffff);
    endcase
  endfunction

  initial begin
    logic [3:0] op;
    logic signed [31:0] bn;
    int mode, r, gap;
    rat_sb = new();
    hold_req = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_ADD;
    in_a_numer <= 0;
    in_a_denom <= 1;
    in_b_numer <= 0;
    in_b_denom <= 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every operation, division and modulo by zero.
    send_item(OP_ADD, 32'sh7fffffff, 31'h7fffffff, 32'sh7fffffff, 31'h7fffffff, 0);
    send_item(OP_SUB, 32'sh80000000, 31'h7fffffff, 32'sh7fffffff, 31'd1, 1);
    send_item(OP_MUL, 32'sh80000000, 31'd1, 32'sh80000000, 31'd1, 0);
    send_item(OP_DIV, 32'sh80000000, 31'h7fffffff, -1, 31'h7fffffff, 2);
    send_item(OP_DIV, 5, 31'd3, 0, 31'd7, 0);
    send_item(OP_MOD, 32'sh80000000, 31'd1, -1, 31'd1, 0);
    send_item(OP_MOD, -7, 31'd1, 3, 31'd1, 0);
    send_item(OP_MOD, 9, 31'd1, 0, 31'd1, 0);
    send_item(OP_ADD, 3, 31'd4, -3, 31'd4, 0);
    send_item(OP_MUL, 0, 31'd9, -5, 31'd2, 0);
    send_item(OP_SUB, 6, 31'd4, 10, 31'd8, 0);
    send_item(OP_DIV, 6, 31'd4, -3, 31'd8, 0);
    send_item(OP_GT, 1, 31'd2, 1, 31'd3, 0);
    send_item(OP_GT, 1, 31'd3, 1, 31'd2, 0);
    send_item(OP_GTE, 2, 31'd4, 1, 31'd2, 0);
    send_item(OP_LT, 32'sh80000000, 31'h7fffffff, 32'sh7fffffff, 31'h7fffffff, 0);
    send_item(OP_LTE, 2, 31'd4, 1, 31'd2, 3);
    send_item(OP_EQ, 2, 31'd4, 1, 31'd2, 0);
    send_item(OP_EQ, -1, 31'd3, 1, 31'd3, 0);
    send_item(4'd10, 1, 31'd1, 1, 31'd1, 0);
    send_item(4'd15, -1, 31'h7fffffff, -1, 31'h7fffffff, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) hold_req = 600;
      if (i == 800) begin
        in_valid <= 1'b0;
        while (rat_sb.pending() != 0) @(posedge clk);
      end
      op = $urandom_range(OP_ADD, OP_EQ);
      r = $urandom_range(0, 99);
      mode = (r < 70) ? 0 : (r < 82) ? 1 : 2;
      bn = pick_numer(mode);
      if ((op == OP_DIV || op == OP_MOD) && $urandom_range(0, 19) == 0) bn = 0;
      gap = (i >= 1200 && i < 1300) ? 0 : idle_len();
      send_item(op, pick_numer(mode), pick_denom(mode), bn, pick_denom(mode), gap);
    end
    in_valid <= 1'b0;

    while (rat_sb.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (rat_sb.errors == 0 && rat_sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
